/* sv/sspq_pkg.sv */
package sspq_pkg;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_ENQ   = 2'd0;
    localparam status_t STATUS_DEQ   = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;
    localparam status_t STATUS_FULL  = 2'd3;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

endpackage

/* sv/sspq_ram.sv */
module sspq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/stable_sorted_priority_queue.sv */
// Stable sorted priority queue, highest priority at the head, FIFO among equals.
// Input channel s_*: s_tuser selects enqueue or dequeue, s_tdata carries the
// priority and payload of an entry to insert. Output channel m_*: one result
// transaction per input transaction, m_tuser gives the status, m_tdata the
// removed head entry (zero unless dequeued) and the occupancy after the step.
// Entries live in one synchronous memory organized as a ring with a head
// pointer; dequeue reads the head, enqueue walks back from the tail, moving one
// lower-priority entry up per cycle until the insertion point is found.
// A rejected or underflowing operation and an enqueue into an empty queue go
// from acceptance straight to the result state; a dequeue first reads the head
// entry, other enqueues first walk the stored entries. One operation is in
// work at a time; the next is accepted the cycle after the result is handed to
// the output register, which is bounded by the one-entry-per-cycle memory walk.
// A stalled receiver holds the output register; the block may still accept and
// process one more operation, which then waits until the output register frees.
// Reset empties the queue and drops any pending result; memory is not cleared.
module stable_sorted_priority_queue #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 16,
    parameter int PRIO_BITS    = 8,
    localparam int IN_W  = ((PRIO_BITS + PAYLOAD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((PAYLOAD_BITS + PRIO_BITS + $clog2(DEPTH + 1) + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,   // prio, payload
    input  logic [0:0]          s_tuser,   // op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // out_payload, out_prio, occupancy
    output sspq_pkg::status_t   m_tuser    // status
);

    import sspq_pkg::*;

    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int ENTRY_BITS = PRIO_BITS + PAYLOAD_BITS;

    localparam logic [CNT_BITS-1:0]  CNT_FULL  = CNT_BITS'(DEPTH);
    localparam logic [ADDR_BITS-1:0] ADDR_LAST = ADDR_BITS'(DEPTH - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_INS  = 3'd2;
    localparam logic [2:0] ST_DEQ  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [ADDR_BITS-1:0]    head_reg, head_next;
    logic [CNT_BITS-1:0]     count_reg, count_next;
    logic [ADDR_BITS-1:0]    k_reg, k_next;
    logic [PRIO_BITS-1:0]    new_prio_reg, new_prio_next;
    logic [PAYLOAD_BITS-1:0] new_payload_reg, new_payload_next;
    status_t                 res_status_reg, res_status_next;
    logic [PRIO_BITS-1:0]    res_prio_reg, res_prio_next;
    logic [PAYLOAD_BITS-1:0] res_payload_reg, res_payload_next;
    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic [PRIO_BITS-1:0]    m_prio_reg, m_prio_next;
    logic [PAYLOAD_BITS-1:0] m_payload_reg, m_payload_next;
    logic [CNT_BITS-1:0]     m_occ_reg, m_occ_next;

    logic                    in_op;
    logic [PRIO_BITS-1:0]    in_prio;
    logic [PAYLOAD_BITS-1:0] in_payload;

    logic                    ram_we;
    logic [ADDR_BITS-1:0]    ram_waddr;
    logic [ENTRY_BITS-1:0]   ram_wdata;
    logic                    ram_re;
    logic [ADDR_BITS-1:0]    ram_raddr;
    logic [ENTRY_BITS-1:0]   ram_rdata;
    logic [PRIO_BITS-1:0]    rd_prio;
    logic [PAYLOAD_BITS-1:0] rd_payload;
    logic [ADDR_BITS-1:0]    count_m1;

    function automatic logic [ADDR_BITS-1:0] to_phys(
        input logic [ADDR_BITS-1:0] head,
        input logic [ADDR_BITS-1:0] idx
    );
        logic [ADDR_BITS:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (ADDR_BITS + 1)'(DEPTH))
        begin
            sum = sum - (ADDR_BITS + 1)'(DEPTH);
        end
        return sum[ADDR_BITS-1:0];
    endfunction

    assign in_op      = s_tuser[0];
    assign in_prio    = s_tdata[PRIO_BITS-1:0];
    assign in_payload = s_tdata[ENTRY_BITS-1:PRIO_BITS];

    assign rd_prio    = ram_rdata[PRIO_BITS-1:0];
    assign rd_payload = ram_rdata[ENTRY_BITS-1:PRIO_BITS];
    assign count_m1   = ADDR_BITS'(count_reg - CNT_BITS'(1));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = OUT_W'({m_occ_reg, m_prio_reg, m_payload_reg});

    sspq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ENTRY_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        k_next           = k_reg;
        new_prio_next    = new_prio_reg;
        new_payload_next = new_payload_reg;
        res_status_next  = res_status_reg;
        res_prio_next    = res_prio_reg;
        res_payload_next = res_payload_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_prio_next      = m_prio_reg;
        m_payload_next   = m_payload_reg;
        m_occ_next       = m_occ_reg;
        ram_we           = 1'b0;
        ram_waddr        = head_reg;
        ram_wdata        = {new_payload_reg, new_prio_reg};
        ram_re           = 1'b0;
        ram_raddr        = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    new_prio_next    = in_prio;
                    new_payload_next = in_payload;
                    res_prio_next    = '0;
                    res_payload_next = '0;
                    priority if (in_op == OP_DEQ && count_reg == '0)
                    begin
                        res_status_next = STATUS_EMPTY;
                        state_next      = ST_DONE;
                    end
                    else if (in_op == OP_DEQ)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = head_reg;
                        state_next = ST_DEQ;
                    end
                    else if (count_reg == CNT_FULL)
                    begin
                        res_status_next = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = head_reg;
                        ram_wdata       = {in_payload, in_prio};
                        count_next      = count_reg + CNT_BITS'(1);
                        res_status_next = STATUS_ENQ;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = to_phys(head_reg, count_m1);
                        k_next     = count_m1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                ram_we    = 1'b1;
                ram_waddr = to_phys(head_reg, k_reg + ADDR_BITS'(1));
                if (rd_prio < new_prio_reg)
                begin
                    ram_wdata = ram_rdata;
                    if (k_reg == '0)
                    begin
                        state_next = ST_INS;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = to_phys(head_reg, k_reg - ADDR_BITS'(1));
                        k_next    = k_reg - ADDR_BITS'(1);
                    end
                end
                else
                begin
                    ram_wdata       = {new_payload_reg, new_prio_reg};
                    count_next      = count_reg + CNT_BITS'(1);
                    res_status_next = STATUS_ENQ;
                    state_next      = ST_DONE;
                end
            end
            ST_INS:
            begin
                ram_we          = 1'b1;
                ram_waddr       = head_reg;
                ram_wdata       = {new_payload_reg, new_prio_reg};
                count_next      = count_reg + CNT_BITS'(1);
                res_status_next = STATUS_ENQ;
                state_next      = ST_DONE;
            end
            ST_DEQ:
            begin
                res_prio_next    = rd_prio;
                res_payload_next = rd_payload;
                head_next        = (head_reg == ADDR_LAST) ? '0 : head_reg + ADDR_BITS'(1);
                count_next       = count_reg - CNT_BITS'(1);
                res_status_next  = STATUS_DEQ;
                state_next       = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_prio_next    = res_prio_reg;
                    m_payload_next = res_payload_reg;
                    m_occ_next     = count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg           <= k_next;
        new_prio_reg    <= new_prio_next;
        new_payload_reg <= new_payload_next;
        res_status_reg  <= res_status_next;
        res_prio_reg    <= res_prio_next;
        res_payload_reg <= res_payload_next;
        m_status_reg    <= m_status_next;
        m_prio_reg      <= m_prio_next;
        m_payload_reg   <= m_payload_next;
        m_occ_reg       <= m_occ_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count exceeds depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != ST_IDLE)
        else $error("accepted transaction did not start work");

    a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_status_reg == STATUS_FULL |-> m_occ_reg == CNT_FULL)
        else $error("full reject reported with queue not full");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_status_reg == STATUS_EMPTY
            |-> m_occ_reg == '0 && m_payload_reg == '0 && m_prio_reg == '0)
        else $error("underflow result not clean");
`endif

endmodule

/* dv/stable_sorted_priority_queue_tb.sv */
`timescale 1ns / 100ps

module stable_sorted_priority_queue_tb;
    import sspq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 16;
    localparam int PRIO_BITS    = 8;
    localparam int IN_W         = 24;
    localparam int OUT_W        = 32;
    localparam int OCC_BITS     = 5;
    localparam int RAND_ITEMS   = 1850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int DIR_ROWS     = 25;

    typedef enum logic [1:0] {
        PRIO_TIES,
        PRIO_FULL,
        PRIO_EXTREME
    } prio_mode_t;

    typedef struct packed {
        status_t                 status;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [PRIO_BITS-1:0]    prio;
        logic [OCC_BITS-1:0]     occupancy;
    } queue_result_t;

    typedef struct packed {
        logic                    op;
        logic [PRIO_BITS-1:0]    prio;
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    typed;
        queue_result_t           result;
    } stim_row_t;

    localparam queue_result_t NO_RESULT = '{STATUS_ENQ, 16'h0000, 8'h00, 5'd0};

    localparam stim_row_t STIM_TABLE [DIR_ROWS] = '{
        '{OP_DEQ, 8'h00, 16'h0000, 1'b1, '{STATUS_EMPTY, 16'h0000, 8'h00, 5'd0}},
        '{OP_ENQ, 8'h00, 16'h0000, 1'b1, '{STATUS_ENQ,   16'h0000, 8'h00, 5'd1}},
        '{OP_ENQ, 8'hFF, 16'hFFFF, 1'b1, '{STATUS_ENQ,   16'h0000, 8'h00, 5'd2}},
        '{OP_DEQ, 8'h00, 16'h0000, 1'b1, '{STATUS_DEQ,   16'hFFFF, 8'hFF, 5'd1}},
        '{OP_DEQ, 8'hFF, 16'hFFFF, 1'b1, '{STATUS_DEQ,   16'h0000, 8'h00, 5'd0}},
        '{OP_DEQ, 8'hFF, 16'hFFFF, 1'b1, '{STATUS_EMPTY, 16'h0000, 8'h00, 5'd0}},
        '{OP_ENQ, 8'h80, 16'h1001, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'h80, 16'h1002, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'h01, 16'h1003, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'hFE, 16'h1004, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'h80, 16'h1005, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'h00, 16'h1006, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'hFF, 16'h1007, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'h01, 16'h1008, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'h80, 16'h1009, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'hFE, 16'h100A, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'hFF, 16'h100B, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'h00, 16'h100C, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'h7F, 16'h100D, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'h80, 16'h100E, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'h01, 16'h100F, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'h80, 16'h1010, 1'b0, NO_RESULT},
        '{OP_ENQ, 8'hAA, 16'h5555, 1'b1, '{STATUS_FULL, 16'h0000, 8'h00, 5'd16}},
        '{OP_DEQ, 8'h00, 16'h0000, 1'b0, NO_RESULT},
        '{OP_DEQ, 8'h00, 16'h0000, 1'b0, NO_RESULT}
    };

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // prio, payload
    logic [0:0]       s_tuser;   // op
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // out_payload, out_prio, occupancy
    status_t          m_tuser;   // status

    logic [PRIO_BITS-1:0]    store_prio [DEPTH];
    logic [PAYLOAD_BITS-1:0] store_payload [DEPTH];
    int unsigned             store_count;

    queue_result_t results_due [$];
    queue_result_t oldest;
    int unsigned   mismatches;
    int unsigned   cycle_count;
    int unsigned   rand_sent;
    int unsigned   hold_left;
    bit            hold_done;
    bit            no_idle;

    stable_sorted_priority_queue #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .PRIO_BITS    (PRIO_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic queue_result_t queue_apply(input logic op,
                                                  input logic [PRIO_BITS-1:0] prio,
                                                  input logic [PAYLOAD_BITS-1:0] payload);
        queue_result_t res;
        int unsigned   pos;
        res = NO_RESULT;
        if (op == OP_ENQ)
        begin
            if (store_count >= DEPTH)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < store_count && store_prio[pos] >= prio)
                    pos++;
                for (int i = store_count; i > pos; i--)
                begin
                    store_prio[i]    = store_prio[i-1];
                    store_payload[i] = store_payload[i-1];
                end
                store_prio[pos]    = prio;
                store_payload[pos] = payload;
                store_count++;
                res.status = STATUS_ENQ;
            end
        end
        else if (store_count == 0)
        begin
            res.status = STATUS_EMPTY;
        end
        else
        begin
            res.status  = STATUS_DEQ;
            res.payload = store_payload[0];
            res.prio    = store_prio[0];
            for (int i = 1; i < store_count; i++)
            begin
                store_prio[i-1]    = store_prio[i];
                store_payload[i-1] = store_payload[i];
            end
            store_count--;
        end
        res.occupancy = store_count[OCC_BITS-1:0];
        return res;
    endfunction

    function automatic logic [PRIO_BITS-1:0] pick_prio(input prio_mode_t mode);
        logic [PRIO_BITS-1:0] p;
        case (mode)
            PRIO_TIES:    p = PRIO_BITS'($urandom_range(0, 3)) + 8'h7E;
            PRIO_EXTREME: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:      p = PRIO_BITS'($urandom_range(0, 255));
        endcase
        return p;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        mismatches++;
    endtask

    task automatic send_op(input logic op, input logic [PRIO_BITS-1:0] prio,
                           input logic [PAYLOAD_BITS-1:0] payload, input logic typed,
                           input queue_result_t typed_result);
        queue_result_t res;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {payload, prio};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        res = queue_apply(op, prio, payload);
        results_due.push_back(typed ? typed_result : res);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("stable_sorted_priority_queue_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
            begin
                flag_mismatch("unexpected transaction, status", m_tuser, 0);
            end
            else
            begin
                oldest = results_due.pop_front();
                if (m_tuser !== oldest.status)
                    flag_mismatch("status", m_tuser, oldest.status);
                if (m_tdata[15:0] !== oldest.payload)
                    flag_mismatch("out_payload", m_tdata[15:0], oldest.payload);
                if (m_tdata[23:16] !== oldest.prio)
                    flag_mismatch("out_prio", m_tdata[23:16], oldest.prio);
                if (m_tdata[28:24] !== oldest.occupancy)
                    flag_mismatch("occupancy", m_tdata[28:24], oldest.occupancy);
            end
        end
    end

    // hold off the receiver once for a long stretch so the block stalls
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && rand_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (no_idle)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= 28);
            end
        end
    end

    initial
    begin
        int unsigned          enq_pct;
        prio_mode_t           mode;
        logic                 op;
        logic [PRIO_BITS-1:0] prio;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_ENQ;
        rst_n       = 1'b0;
        store_count = 0;
        rand_sent   = 0;
        no_idle     = 1'b0;
        enq_pct     = 50;
        mode        = PRIO_FULL;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_op(STIM_TABLE[r].op, STIM_TABLE[r].prio, STIM_TABLE[r].payload,
                    STIM_TABLE[r].typed, STIM_TABLE[r].result);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            // vary fill bias and priority spread every 64 transactions
            if (n % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       enq_pct = 15;
                    1:       enq_pct = 50;
                    2:       enq_pct = 70;
                    default: enq_pct = 92;
                endcase
                mode = prio_mode_t'($urandom_range(0, 2));
            end
            no_idle = (n >= 800 && n < 1100);
            op   = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
            prio = pick_prio(mode);
            send_op(op, prio, PAYLOAD_BITS'($urandom_range(0, 65535)), 1'b0, NO_RESULT);
            rand_sent++;
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("stable_sorted_priority_queue_tb passed");
        else
            $display("stable_sorted_priority_queue_tb failed");
        $finish;
    end

endmodule
